// ----- design/atipd_pkg.sv -----
`default_nettype none

package atipd_pkg;

   // Terminator selector codes (other codes behave as none)
   localparam logic [2:0] TERM_NONE    = 3'd0;
   localparam logic [2:0] TERM_OK      = 3'd1;
   localparam logic [2:0] TERM_SEND_OK = 3'd2;
   localparam logic [2:0] TERM_PROMPT  = 3'd3;
   localparam logic [2:0] TERM_READY   = 3'd4;

   // Terminator text, right aligned, first character in the highest used byte
   localparam logic [71:0] TXT_OK      = 72'("OK\015\012");
   localparam logic [71:0] TXT_SEND_OK = 72'("SEND OK\015\012");
   localparam logic [71:0] TXT_PROMPT  = 72'("> ");
   localparam logic [71:0] TXT_READY   = 72'("ready\015\012");

   // Characters of the request header
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_I      = 8'h49;
   localparam logic [7:0] CH_P      = 8'h50;
   localparam logic [7:0] CH_D      = 8'h44;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DIGIT0 = 8'd48;

   // Quiet countdown start value after a full terminator match
   localparam logic [3:0] QUIET_ARM  = 4'd10;
   localparam logic [3:0] QUIET_DONE = 4'd1;
   localparam logic [3:0] MATCH_MAX  = 4'd8;

   // Input word
   typedef struct packed {
      logic       mode;
      logic [7:0] byte_value;
   } req_type;

   // Result word
   typedef struct packed {
      logic       route_valid;
      logic [7:0] route_byte;
      logic       request_done;
      logic [7:0] channel_out;
      logic       end_found;
   } rsp_type;

   // Item being processed this cycle
   typedef struct packed {
      logic       fire;
      logic       tick;
      logic [7:0] data;
   } step_type;

   // Header parser status toward the top level
   typedef struct packed {
      logic       route_valid;
      logic [7:0] route_byte;
      logic       done;
      logic [7:0] channel;
   } hdr_status_type;

   // Terminator length for a selector code
   function automatic logic [3:0] term_len(input logic [2:0] sel);
      logic [3:0] len;
      unique case (sel)
         TERM_OK:      len = 4'd4;
         TERM_SEND_OK: len = 4'd9;
         TERM_PROMPT:  len = 4'd2;
         TERM_READY:   len = 4'd7;
         default:      len = 4'd0;
      endcase
      return len;
   endfunction

   // Terminator character at a position, zero beyond its end
   function automatic logic [7:0] term_char(input logic [2:0] sel, input logic [3:0] pos);
      logic [71:0] txt;
      logic [3:0]  len;
      logic [3:0]  back;
      logic [7:0]  ch;
      unique case (sel)
         TERM_OK:      txt = TXT_OK;
         TERM_SEND_OK: txt = TXT_SEND_OK;
         TERM_PROMPT:  txt = TXT_PROMPT;
         TERM_READY:   txt = TXT_READY;
         default:      txt = '0;
      endcase
      len  = term_len(sel);
      back = len - 4'd1 - pos;
      if (pos < len) begin
         ch = txt[{back, 3'b000} +: 8];
      end else begin
         ch = '0;
      end
      return ch;
   endfunction

endpackage

`default_nettype wire

// ----- design/atipd_header.sv -----
`default_nettype none

module atipd_header (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire atipd_pkg::step_type       step,
   input  wire logic                     clear,
   output atipd_pkg::hdr_status_type      status
);
   import atipd_pkg::*;

   typedef enum logic [10:0] {
      HDR_IDLE   = 11'b000_0000_0001,
      HDR_PLUS   = 11'b000_0000_0010,
      HDR_I      = 11'b000_0000_0100,
      HDR_P      = 11'b000_0000_1000,
      HDR_D      = 11'b000_0001_0000,
      HDR_CHAN   = 11'b000_0010_0000,
      HDR_LEN    = 11'b000_0100_0000,
      HDR_METHOD = 11'b000_1000_0000,
      HDR_ROUTE  = 11'b001_0000_0000,
      HDR_DONE   = 11'b010_0000_0000,
      HDR_LINE   = 11'b100_0000_0000
   } hdr_state_type;

   hdr_state_type state_ff, state_in;
   logic [7:0]    chan_ff, chan_in;
   logic [7:0]    chan_next;
   logic          is_eol;
   logic          route_valid;

   // Decimal accumulate: chan * 10 + c - '0', modulo 256
   assign chan_next = {chan_ff[4:0], 3'b000} + {chan_ff[6:0], 1'b0} + step.data - CH_DIGIT0;
   assign is_eol    = (step.data == CH_CR) || (step.data == CH_LF);

   // Advance the header parser on a byte, drop everything on a reporting tick
   always_comb begin
      state_in    = state_ff;
      chan_in     = chan_ff;
      route_valid = 1'b0;
      if (step.fire && step.tick) begin
         if (clear) begin
            state_in = HDR_IDLE;
            chan_in  = '0;
         end
      end else if (step.fire) begin
         unique case (state_ff)
            HDR_IDLE: begin
               if (step.data == CH_PLUS) begin
                  state_in = HDR_PLUS;
               end else if (!is_eol) begin
                  state_in = HDR_LINE;
               end
            end
            HDR_LINE: begin
               if (is_eol) begin
                  state_in = HDR_IDLE;
               end
            end
            HDR_PLUS: state_in = (step.data == CH_I) ? HDR_I : HDR_IDLE;
            HDR_I:    state_in = (step.data == CH_P) ? HDR_P : HDR_IDLE;
            HDR_P:    state_in = (step.data == CH_D) ? HDR_D : HDR_IDLE;
            HDR_D: begin
               if (step.data == CH_COMMA) begin
                  state_in = HDR_CHAN;
                  chan_in  = '0;
               end else begin
                  state_in = HDR_IDLE;
               end
            end
            HDR_CHAN: begin
               if (step.data == CH_COMMA) begin
                  state_in = HDR_LEN;
               end else begin
                  chan_in = chan_next;
               end
            end
            HDR_LEN: begin
               if (step.data == CH_COLON) begin
                  state_in = HDR_METHOD;
               end
            end
            HDR_METHOD: begin
               if (step.data == CH_SPACE) begin
                  state_in = HDR_ROUTE;
               end
            end
            HDR_ROUTE: begin
               if (step.data == CH_SPACE) begin
                  state_in = HDR_DONE;
               end else begin
                  route_valid = 1'b1;
               end
            end
            HDR_DONE: state_in = HDR_DONE;
            default:  state_in = HDR_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= HDR_IDLE;
         chan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
      end
   end

   assign status.route_valid = route_valid;
   assign status.route_byte  = route_valid ? step.data : 8'd0;
   assign status.done        = (state_ff == HDR_DONE);
   assign status.channel     = chan_ff;

`ifndef SYNTHESIS
   // A reporting tick leaves the parser idle with a cleared channel
   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      step.fire && step.tick && clear |=> state_ff == HDR_IDLE && chan_ff == 8'd0)
      else $error("header parser not cleared after report");
   // Route bytes only come out of the route state
   a_route_state: assert property (@(posedge clock) disable iff (reset)
      route_valid |-> state_ff == HDR_ROUTE && !step.tick)
      else $error("route byte outside route state");
   // The channel restarts from zero when its digits begin
   a_chan_start: assert property (@(posedge clock) disable iff (reset)
      step.fire && !step.tick && state_ff == HDR_D && step.data == CH_COMMA
      |=> chan_ff == 8'd0)
      else $error("channel not restarted");
`endif

endmodule

`default_nettype wire

// ----- design/atipd_term.sv -----
`default_nettype none

module atipd_term (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire atipd_pkg::step_type  step,
   input  wire logic [2:0]          response_type,
   input  wire logic                clear,
   output logic                     end_hit
);
   import atipd_pkg::*;

   logic [3:0] match_ff, match_in;
   logic [3:0] quiet_ff, quiet_in;
   logic [3:0] len;
   logic [3:0] last;
   logic [7:0] ch_cur;
   logic [7:0] ch_first;
   logic [3:0] match_mid;
   logic [3:0] quiet_dec;

   assign len       = term_len(response_type);
   assign last      = len - 4'd1;
   assign ch_cur    = term_char(response_type, match_ff);
   assign ch_first  = term_char(response_type, 4'd0);
   assign quiet_dec = (quiet_ff > QUIET_DONE) ? quiet_ff - 4'd1 : quiet_ff;

   // Accept the terminator once the countdown reaches one with no partial match
   assign end_hit = step.fire && step.tick && (len != 4'd0)
                    && (quiet_dec == QUIET_DONE) && (match_ff == 4'd0);

   // Track the terminator match and the quiet countdown
   always_comb begin
      match_in  = match_ff;
      quiet_in  = quiet_ff;
      match_mid = match_ff;
      if (step.fire && step.tick) begin
         if (clear) begin
            match_in = '0;
            quiet_in = '0;
         end else begin
            quiet_in = quiet_dec;
         end
      end else if (step.fire && len != 4'd0) begin
         if (match_ff == last && step.data == ch_cur) begin
            match_mid = '0;
            quiet_in  = QUIET_ARM;
         end else if (match_ff < last) begin
            if (step.data == ch_cur) begin
               match_mid = match_ff + 4'd1;
            end else begin
               match_mid = '0;
               quiet_in  = '0;
            end
         end else begin
            match_mid = '0;
            quiet_in  = '0;
         end
         // Restart the match on the first terminator character
         if (match_mid == 4'd0 && step.data == ch_first) begin
            match_in = 4'd1;
         end else begin
            match_in = match_mid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= '0;
         quiet_ff <= '0;
      end else begin
         match_ff <= match_in;
         quiet_ff <= quiet_in;
      end
   end

`ifndef SYNTHESIS
   // Countdown never exceeds its start value
   a_quiet_range: assert property (@(posedge clock) disable iff (reset)
      quiet_ff <= QUIET_ARM)
      else $error("quiet count out of range");
   // Match position stays inside the longest terminator
   a_match_range: assert property (@(posedge clock) disable iff (reset)
      match_ff <= MATCH_MAX)
      else $error("match position out of range");
   // Accepting the terminator clears the matcher
   a_end_clear: assert property (@(posedge clock) disable iff (reset)
      end_hit && clear |=> match_ff == 4'd0 && quiet_ff == 4'd0)
      else $error("matcher not cleared after terminator");
`endif

endmodule

`default_nettype wire

// ----- design/at_response_ipd_parser.sv -----
`default_nettype none

// Channel   Direction  Handshake             Word
// req       in         req_valid/req_stall   atipd_pkg::req_type (mode, byte_value)
// rsp       out        rsp_valid/rsp_stall   atipd_pkg::rsp_type (one per req word)
// csr       in         csr_wr_en             csr_wr_data = response_type
//
// One word per cycle unless stalled; a word passes input, then result register.
// Each word is parsed in a single pass between the input register and the
// result register; header and terminator state update in that same cycle.
// Synchronous active-high reset clears parser state and selects no terminator.
// rsp_stall on a waiting result holds the result register and, with the input
// register full, raises req_stall in the same cycle.

module at_response_ipd_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire atipd_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output atipd_pkg::rsp_type       rsp_data,
   input  wire logic               csr_wr_en,
   input  wire logic [2:0]         csr_wr_data
);
   import atipd_pkg::*;

   logic           in_valid_ff;
   req_type        in_word_ff;
   logic           out_valid_ff;
   rsp_type        out_word_ff, out_word_in;
   logic [2:0]     resp_type_ff;
   logic           advance;
   logic           fire;
   step_type       step;
   hdr_status_type hdr_status;
   logic           end_hit;
   logic           clear;

   // Move the result stage when it is empty or being taken
   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   assign step.fire = fire;
   assign step.tick = in_word_ff.mode;
   assign step.data = in_word_ff.byte_value;

   // Clear all parser state on a tick that reports something
   assign clear = step.tick && (end_hit || hdr_status.done);

   atipd_header u_header (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .clear  (clear),
      .status (hdr_status)
   );

   atipd_term u_term (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .response_type (resp_type_ff),
      .clear         (clear),
      .end_hit       (end_hit)
   );

   // Build the result word; the terminator wins over a finished header
   always_comb begin
      out_word_in = '0;
      if (step.tick) begin
         out_word_in.end_found = end_hit;
         if (!end_hit && hdr_status.done) begin
            out_word_in.request_done = 1'b1;
            out_word_in.channel_out  = hdr_status.channel;
         end
      end else begin
         out_word_in.route_valid = hdr_status.route_valid;
         out_word_in.route_byte  = hdr_status.route_byte;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_word_ff <= req_data;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_word_ff <= out_word_in;
      end
   end

   // Terminator selector
   always_ff @(posedge clock) begin
      if (reset) begin
         resp_type_ff <= TERM_NONE;
      end else if (csr_wr_en) begin
         resp_type_ff <= csr_wr_data;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_word_ff;

`ifndef SYNTHESIS
   // A processed word shows up as a result in the next cycle
   a_fire_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("processed word lost");
   // A result never carries a route byte together with a tick report
   a_route_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.route_valid
                      && (rsp_data.request_done || rsp_data.end_found)))
      else $error("route byte mixed with tick report");
   // Only one tick report at a time, channel only with a finished header
   a_one_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.request_done |-> rsp_data.channel_out == 8'd0)
      else $error("channel reported without request");
   a_no_both: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.request_done && rsp_data.end_found))
      else $error("both reports on one tick");
`endif

endmodule

`default_nettype wire
